// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the bit packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HCBP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hcbp: checker property failed");

// Check a property on every clock edge, reset included.
`define HCBP_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("hcbp: reset property failed");

`endif

// ----- design/hcbp_pkg.sv -----
// Shared types and constants of the code bit packer.
package hcbp_pkg;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_FLUSH  = 2'd2
   } req_kind_type;

   localparam int SYM_W       = 8;
   localparam int LEN_W       = 6;
   localparam int CODE_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 4;
   // pending bits (at most a byte minus one) plus one full code
   localparam int ACC_W       = CODE_W + BYTE_W - 1;
   localparam int ACC_CNT_W   = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic              is_flush;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } work_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic [COUNT_W-1:0] bit_count;
      logic               is_final;
      logic               last;
   } result_type;

endpackage

// ----- design/hcbp_front.sv -----
// Front end: code table, request decode and work item build.
module hcbp_front #(
   parameter int SYMBOLS      = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [1:0]                      in_kind,
   input  logic [hcbp_pkg::SYM_W-1:0]      in_symbol,
   input  logic [hcbp_pkg::LEN_W-1:0]      in_length,
   input  logic [hcbp_pkg::CODE_W-1:0]     in_code,
   output logic                            push_valid,
   input  logic                            push_ready,
   output hcbp_pkg::work_type              push_work
);
   import hcbp_pkg::*;

   localparam int IDX_W   = $clog2(SYMBOLS);
   localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   logic [LEN_W-1:0]  len_mem  [SYMBOLS];
   logic [CODE_W-1:0] code_mem [SYMBOLS];
   logic [SYMBOLS-1:0] written_ff, written_in;

   req_kind_type      kind;
   logic              accept;
   logic              in_range;
   logic [IDX_W-1:0]  idx;
   logic [LEN_W-1:0]  cap_len;
   logic              wr_en;

   logic              s1_valid_ff, s1_valid_in;
   req_kind_type      kind_ff;
   logic              rd_range_ff;
   logic              rd_written_ff;
   logic [LEN_W-1:0]  rd_len_ff;
   logic [CODE_W-1:0] rd_code_ff;

   logic [LEN_W-1:0]  eff_len;
   logic [CODE_W:0]   code_mask;
   logic              needs_push;
   logic              s1_advance;

   assign kind     = req_kind_type'(in_kind);
   assign accept   = in_valid && in_ready;
   assign in_range = {1'b0, in_symbol} < (SYM_W + 1)'(SYMBOLS);
   assign idx      = in_symbol[IDX_W-1:0];
   assign cap_len  = (in_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_length;
   assign wr_en    = accept && (kind == REQ_LOAD) && in_range;

   // table write and registered read share the accept edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         len_mem[idx]  <= cap_len;
         code_mem[idx] <= in_code;
      end
      if (accept) begin
         rd_len_ff     <= len_mem[idx];
         rd_code_ff    <= code_mem[idx];
         rd_written_ff <= written_ff[idx];
         rd_range_ff   <= in_range;
         kind_ff       <= kind;
      end
   end

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[idx] = 1'b1;
      end
   end

   // an entry never written reads as length zero
   assign eff_len    = (rd_written_ff && rd_range_ff) ? rd_len_ff : '0;
   assign code_mask  = ((CODE_W + 1)'(1) << eff_len) - (CODE_W + 1)'(1);
   assign needs_push = (kind_ff == REQ_FLUSH) ||
                       ((kind_ff == REQ_ENCODE) && (eff_len != '0));
   assign s1_advance = !needs_push || push_ready;
   assign in_ready   = !s1_valid_ff || s1_advance;

   assign push_valid         = s1_valid_ff && needs_push;
   assign push_work.is_flush = (kind_ff == REQ_FLUSH);
   assign push_work.len      = eff_len;
   assign push_work.code     = rd_code_ff & code_mask[CODE_W-1:0];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         written_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         written_ff  <= written_in;
      end
   end

endmodule

// ----- design/hcbp_queue.sv -----
// Short work queue between the front end and the packer.
module hcbp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  hcbp_pkg::work_type wr_data,
   output logic               rd_valid,
   input  logic               rd_ready,
   output hcbp_pkg::work_type rd_data
);
   import hcbp_pkg::*;

   work_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_wr, do_rd;

   assign wr_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = entries_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/hcbp_back.sv -----
// Back end: bit accumulator, byte split and result register.
module hcbp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  hcbp_pkg::work_type   pop_work,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hcbp_pkg::result_type out_result
);
   import hcbp_pkg::*;

   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ACC_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   result_type           result_ff;

   logic                 out_free;
   logic                 have_byte;
   logic                 final_byte;
   logic [ACC_CNT_W-1:0] byte_shift;
   logic [BYTE_W-1:0]    full_byte;
   logic [BYTE_W:0]      flush_mask;
   logic                 emit;
   logic                 pop;
   result_type           res;
   logic [ACC_CNT_W-1:0] base_cnt;

   assign out_free   = !out_valid_ff || out_ready;
   assign have_byte  = cnt_ff >= ACC_CNT_W'(BYTE_W);
   assign final_byte = cnt_ff < ACC_CNT_W'(2 * BYTE_W);
   assign byte_shift = cnt_ff - ACC_CNT_W'(BYTE_W);
   assign full_byte  = BYTE_W'(acc_ff >> byte_shift);
   assign flush_mask = ((BYTE_W + 1)'(1) << cnt_ff[2:0]) - (BYTE_W + 1)'(1);

   always_comb begin
      emit     = 1'b0;
      pop      = 1'b0;
      res      = '0;
      base_cnt = cnt_ff;
      if (have_byte) begin
         if (out_free) begin
            emit          = 1'b1;
            res.out_byte  = full_byte;
            res.bit_count = COUNT_W'(BYTE_W);
            res.last      = final_byte;
            base_cnt      = byte_shift;
            // load the next code while the last byte goes out
            pop = final_byte && pop_valid && !pop_work.is_flush;
         end
      end else if (pop_valid) begin
         if (pop_work.is_flush) begin
            if (out_free) begin
               emit          = 1'b1;
               pop           = 1'b1;
               res.out_byte  = acc_ff[BYTE_W-1:0] & flush_mask[BYTE_W-1:0];
               res.bit_count = {1'b0, cnt_ff[2:0]};
               res.is_final  = 1'b1;
               res.last      = 1'b1;
            end
         end else begin
            pop = 1'b1;
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      cnt_in = base_cnt;
      if (pop) begin
         if (pop_work.is_flush) begin
            cnt_in = '0;
         end else begin
            acc_in = (acc_ff << pop_work.len) | ACC_W'(pop_work.code);
            cnt_in = base_cnt + ACC_CNT_W'(pop_work.len);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign pop_ready  = pop;
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (emit) begin
         result_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- design/huffman_code_bit_packer.sv -----
// Top level of the code bit packer: front end, work queue and packer.
//
// Request channel (req_): one word per request. req_tuser picks the kind:
// load a table entry, encode a symbol, or flush the leftover bits. A load
// writes the code length (capped at MAX_CODE_LEN, at most 32) and the code
// bits for a symbol and gives no response. An encode appends the symbol's
// code to the bit stream, earliest bit first, and gives one response word
// per byte that fills up (none for an absent symbol or a short code). A
// flush gives exactly one word: the 0..7 leftover bits right-aligned, with
// their count and the final flag; the accumulator then starts empty.
// Response channel (rsp_): rsp_tlast marks the last word of a request.
// A flush word passes the table read register, the work queue and the
// response register; an encode's first byte also passes the accumulator.
// Throughput: requests enter at one per cycle while req_tready is high. The
// packer emits one byte a cycle while the receiver takes each word, and
// loads the next code with the last byte of the one before.
// A four-deep queue between front end and packer lets requests enter while
// the packer drains. When the receiver stalls, the response register holds
// its word and the queue fills, then req_tready drops.
// Reset clears the table lengths, the leftover bits and the queue at once;
// req_tready is high in the cycle after reset.
module huffman_code_bit_packer #(
   parameter int SYMBOLS      = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] symbol, [13:8] code_length, [45:14] code_bits, [47:46] zero
   input  logic [47:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte, [11:8] bit_count, [12] is_final, [15:13] zero
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);
   import hcbp_pkg::*;

   logic       push_valid, push_ready;
   work_type   push_work;
   logic       pop_valid, pop_ready;
   work_type   pop_work;
   result_type result;

   // Decode the request and read the code table.
   hcbp_front #(
      .SYMBOLS      (SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_kind    (req_tuser),
      .in_symbol  (req_tdata[7:0]),
      .in_length  (req_tdata[13:8]),
      .in_code    (req_tdata[45:14]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_work  (push_work)
   );

   // Buffer encode and flush work so each side can stall on its own.
   hcbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (push_work),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_data  (pop_work)
   );

   // Pack code bits into bytes and drive the response register.
   hcbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_work   (pop_work),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {3'b000, result.is_final, result.bit_count, result.out_byte};
   assign rsp_tlast = result.last;

endmodule

// ----- design/hcbp_checker.sv -----
// Port-level checker for the code bit packer, bound to the top level.
`include "assert_macros.svh"

module hcbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // hold a stalled response word
   `HCBP_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // words before the last of a request are full, non-final bytes
   `HCBP_ASSERT(a_mid_full, rsp_tvalid && !rsp_tlast |-> rsp_tdata[11:8] == 4'd8 && !rsp_tdata[12])

   // a partial byte only ends the stream, and the final word is partial and last
   `HCBP_ASSERT(a_final_word, rsp_tvalid && (rsp_tdata[12] || rsp_tdata[11:8] != 4'd8) |-> rsp_tdata[12] && rsp_tlast && rsp_tdata[11:8] < 4'd8)

   // come out of reset empty and ready
   `HCBP_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid && req_tready)

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);
